// ===== src/bhl_pkg.sv =====
// Shared package for the streaming lookup2 byte hash.
// Holds constants, the command passed from front to back, and the mix step.
// No dependencies.
package bhl_pkg;

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;
  localparam int BLOCK_BYTES = 12;
  localparam int POS_W = $clog2(BLOCK_BYTES);
  localparam int MIX_STEPS = 9;
  localparam int STEP_W = $clog2(MIX_STEPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        final_cmd;
    logic        fresh;
    logic [31:0] key_seed;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c;
  } cmd_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_t;

  function automatic mix_t mix_step(input logic [STEP_W-1:0] step, input mix_t m);
    mix_t r;
    r = m;
    case (step)
      4'd0: r.a = (m.a - m.b - m.c) ^ (m.c >> 13);
      4'd1: r.b = (m.b - m.c - m.a) ^ (m.a << 8);
      4'd2: r.c = (m.c - m.a - m.b) ^ (m.b >> 13);
      4'd3: r.a = (m.a - m.b - m.c) ^ (m.c >> 12);
      4'd4: r.b = (m.b - m.c - m.a) ^ (m.a << 16);
      4'd5: r.c = (m.c - m.a - m.b) ^ (m.b >> 5);
      4'd6: r.a = (m.a - m.b - m.c) ^ (m.c >> 3);
      4'd7: r.b = (m.b - m.c - m.a) ^ (m.a << 10);
      4'd8: r.c = (m.c - m.a - m.b) ^ (m.b >> 15);
      default: r = m;
    endcase
    return r;
  endfunction

endpackage

// ===== src/bhl_front.sv =====
// Front end: accepts key bytes, gathers 12-byte blocks and issues block and
// final commands to the queue. Holds the seed register. Depends on bhl_pkg.
module bhl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          seed_we,
  input  logic [31:0]   seed_data,
  input  logic [7:0]    data_byte,
  input  logic          has_byte,
  input  logic          last_byte,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          push_valid,
  output bhl_pkg::cmd_t push_cmd,
  input  logic          push_ready
);
  import bhl_pkg::*;

  logic [7:0]       buffer [BLOCK_BYTES];
  logic [POS_W-1:0] pos;
  logic [31:0]      key_len;
  logic             in_key;
  logic             issued;
  logic [31:0]      key_seed;
  logic [31:0]      seed_value;
  logic             pend_valid;
  cmd_t             pend_cmd;

  logic             accept;
  logic             block_done;
  logic             fresh_now;
  logic [31:0]      seed_now;
  logic [31:0]      len_next;
  logic [POS_W-1:0] count;
  logic [7:0]       view [BLOCK_BYTES];
  logic [7:0]       kept [BLOCK_BYTES];
  cmd_t             blk_cmd;
  cmd_t             fin_cmd;

  assign in_ready   = !pend_valid && push_ready;
  assign accept     = in_valid && in_ready;
  assign block_done = has_byte && (pos == POS_W'(BLOCK_BYTES - 1));
  assign fresh_now  = !issued;
  assign seed_now   = in_key ? key_seed : seed_value;
  assign len_next   = key_len + 32'(has_byte);
  assign count      = block_done ? '0 : pos + POS_W'(has_byte);

  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      view[i] = (has_byte && pos == POS_W'(i)) ? data_byte : buffer[i];
      kept[i] = (POS_W'(i) < count) ? view[i] : 8'h00;
    end
  end

  always_comb begin
    blk_cmd.final_cmd = 1'b0;
    blk_cmd.fresh     = fresh_now;
    blk_cmd.key_seed  = seed_now;
    blk_cmd.add_a     = {view[3], view[2], view[1], view[0]};
    blk_cmd.add_b     = {view[7], view[6], view[5], view[4]};
    blk_cmd.add_c     = {view[11], view[10], view[9], view[8]};
    fin_cmd.final_cmd = 1'b1;
    fin_cmd.fresh     = fresh_now && !block_done;
    fin_cmd.key_seed  = seed_now;
    fin_cmd.add_a     = {kept[3], kept[2], kept[1], kept[0]};
    fin_cmd.add_b     = {kept[7], kept[6], kept[5], kept[4]};
    fin_cmd.add_c     = len_next + {kept[10], kept[9], kept[8], 8'h00};
  end

  always_comb begin
    push_valid = 1'b0;
    push_cmd   = fin_cmd;
    if (pend_valid) begin
      push_valid = 1'b1;
      push_cmd   = pend_cmd;
    end else if (accept && block_done) begin
      push_valid = 1'b1;
      push_cmd   = blk_cmd;
    end else if (accept && last_byte) begin
      push_valid = 1'b1;
      push_cmd   = fin_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_byte) begin
      buffer[pos] <= data_byte;
    end
    if (accept && block_done && last_byte) begin
      pend_cmd <= fin_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
      pos        <= '0;
      key_len    <= '0;
      in_key     <= 1'b0;
      issued     <= 1'b0;
      key_seed   <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (seed_we) begin
        seed_value <= seed_data;
      end
      if (pend_valid && push_ready) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (has_byte && !in_key) begin
          key_seed <= seed_value;
          in_key   <= 1'b1;
        end
        if (block_done) begin
          issued <= 1'b1;
        end
        pos     <= count;
        key_len <= len_next;
        if (last_byte) begin
          in_key  <= 1'b0;
          issued  <= 1'b0;
          pos     <= '0;
          key_len <= '0;
          if (block_done) begin
            pend_valid <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== src/bhl_queue.sv =====
// Short command queue between the front and back ends of the hash.
// One push per cycle unless full, one pop unless empty. Depends on bhl_pkg.
module bhl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  bhl_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output bhl_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import bhl_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QPTR_W'(1);
      end
      if (do_pop) begin
        head <= (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + QPTR_W'(1);
      end
      fill <= fill + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ===== src/bhl_back.sv =====
// Back end: adds each block into the mix words and runs the nine-line mix, one line
// per cycle unless the output stalls, and registers final hashes. Depends on bhl_pkg.
module bhl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  bhl_pkg::cmd_t pop_cmd,
  output logic          pop_ready,
  output logic [31:0]   hash_value,
  output logic          out_valid,
  input  logic          out_ready
);
  import bhl_pkg::*;

  typedef enum logic {IDLE, MIX} state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              is_final;
  mix_t              words;
  mix_t              base;
  mix_t              stepped;
  logic              last_step;
  logic              hold;

  assign pop_ready = (state == IDLE);
  assign last_step = (step == STEP_W'(MIX_STEPS - 1));
  assign hold      = last_step && is_final && out_valid && !out_ready;
  assign stepped   = mix_step(step, words);

  always_comb begin
    if (pop_cmd.fresh) begin
      base.a = GOLDEN;
      base.b = GOLDEN;
      base.c = pop_cmd.key_seed;
    end else begin
      base = words;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      is_final  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (pop_valid) begin
            words.a  <= base.a + pop_cmd.add_a;
            words.b  <= base.b + pop_cmd.add_b;
            words.c  <= base.c + pop_cmd.add_c;
            is_final <= pop_cmd.final_cmd;
            step     <= '0;
            state    <= MIX;
          end
        end
        MIX: begin
          if (!hold) begin
            words <= stepped;
            if (last_step) begin
              state <= IDLE;
              if (is_final) begin
                hash_value <= stepped.c;
                out_valid  <= 1'b1;
              end
            end else begin
              step <= step + STEP_W'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/byte_hash_32bit_lookup2.sv =====
// Top level of the streaming 32-bit lookup2 byte hash.
// Instantiates bhl_front, bhl_queue and bhl_back; depends on bhl_pkg.
//
// Usage: the key arrives one byte per input transaction on in_valid/in_ready
// with data_byte, has_byte and last_byte. A transaction with last_byte set
// ends the key; a transaction with has_byte clear and last_byte set on its own
// hashes the empty key. Each key yields one hash transaction on
// out_valid/out_ready carrying hash_value.
// seed_we writes seed_data into the seed register; a key takes the seed that
// is present when its first byte is accepted.
// Throughput: one byte per cycle while in_ready is high. Every twelfth byte
// issues a block mix that occupies the back end for an add step and the nine
// mix lines, overlapping the collection of the next block. Each key also needs
// a final mix of the same steps, which bounds the rate of short keys.
// A key whose last byte completes a block holds in_ready low while its final
// command waits in a pending register. The four-entry command queue absorbs
// bursts of short keys; when it fills, in_ready drops.
// Reset clears the seed to zero and discards any key in progress and any
// pending hash. When the receiver stalls, the finished hash is held in the
// output register and the back end waits before completing the next hash.
module byte_hash_32bit_lookup2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] hash_value,
  output logic        out_valid,
  input  logic        out_ready
);
  import bhl_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  bhl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_data  (seed_data),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last_byte  (last_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  bhl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  bhl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready),
    .hash_value (hash_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

// ===== dv/byte_hash_32bit_lookup2_check.sv =====
`timescale 1ns / 100ps
// Checker for byte_hash_32bit_lookup2: follows seed writes and both transaction
// channels, predicts the lookup2 hash of every key and compares it with each
// hash transaction. Depends on bhl_pkg for the golden ratio and block size.
module byte_hash_32bit_lookup2_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] hash_value,
  input  logic        out_valid,
  input  logic        out_ready,
  output int          mismatches,
  output int          hashes_due
);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lanes_t;

  logic [31:0] expected_hashes[$];
  logic [31:0] seed_reg;
  lanes_t      acc;
  logic [7:0]  key_bytes[bhl_pkg::BLOCK_BYTES];
  int          fill;
  logic [31:0] key_len;
  bit          key_open;
  int          errs;

  function automatic lanes_t lookup2_mix(lanes_t m);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    lanes_t      r;
    a = m.a;
    b = m.b;
    c = m.c;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

  initial begin
    errs = 0;
  end

  always @(posedge clk) begin
    logic [31:0] want;
    logic [31:0] v;
    if (rst) begin
      seed_reg = '0;
      key_open = 1'b0;
      fill = 0;
      key_len = '0;
      expected_hashes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: hash %h arrived with none expected", $time, hash_value);
          errs++;
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value !== want) begin
            $display("%0t: hash mismatch, expected %h, actual %h", $time, want, hash_value);
            errs++;
          end
        end
      end
      if (seed_we) seed_reg = seed_data;
      if (in_valid && in_ready && (has_byte || last_byte)) begin
        if (!key_open) begin
          acc.a = bhl_pkg::GOLDEN;
          acc.b = bhl_pkg::GOLDEN;
          acc.c = seed_reg;
          fill = 0;
          key_len = '0;
          key_open = 1'b1;
        end
        if (has_byte) begin
          key_bytes[fill] = data_byte;
          fill++;
          key_len++;
          if (fill == bhl_pkg::BLOCK_BYTES) begin
            acc.a += {key_bytes[3], key_bytes[2], key_bytes[1], key_bytes[0]};
            acc.b += {key_bytes[7], key_bytes[6], key_bytes[5], key_bytes[4]};
            acc.c += {key_bytes[11], key_bytes[10], key_bytes[9], key_bytes[8]};
            acc = lookup2_mix(acc);
            fill = 0;
          end
        end
        if (last_byte) begin
          acc.c += key_len;
          for (int i = 0; i < fill; i++) begin
            v = {24'h0, key_bytes[i]};
            if (i < 4) acc.a += v << (8 * i);
            else if (i < 8) acc.b += v << (8 * (i - 4));
            else acc.c += v << (8 * (i - 8) + 8);
          end
          acc = lookup2_mix(acc);
          expected_hashes.push_back(acc.c);
          key_open = 1'b0;
        end
      end
    end
    mismatches <= errs;
    hashes_due <= expected_hashes.size();
  end

endmodule

// ===== dv/byte_hash_32bit_lookup2_test.sv =====
`timescale 1ns / 100ps
// Top of the byte_hash_32bit_lookup2 testbench: clock, reset, key stimulus,
// seed changes, receiver stalls and the verdict. Depends on the block, on
// bhl_pkg and on byte_hash_32bit_lookup2_check, which does all the hash checking.
module byte_hash_32bit_lookup2_test;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 170;

  logic        clk;
  logic        rst;
  logic        seed_we;
  logic [31:0] seed_data;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last_byte;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] hash_value;
  logic        out_valid;
  logic        out_ready;
  int          mismatches;
  int          hashes_due;
  int          items_sent;
  int          hashes_taken;
  int          quiet_cycles;
  bit          send_steady;
  bit          take_steady;
  logic [31:0] seed_plan[6];

  byte_hash_32bit_lookup2 uut (
    .clk       (clk),
    .rst       (rst),
    .seed_we   (seed_we),
    .seed_data (seed_data),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hash_value(hash_value),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  byte_hash_32bit_lookup2_check checker_i (
    .clk       (clk),
    .rst       (rst),
    .seed_we   (seed_we),
    .seed_data (seed_data),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hash_value(hash_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mismatches(mismatches),
    .hashes_due(hashes_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("byte_hash_32bit_lookup2 regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] value, input logic has, input logic ends);
    int gap;
    if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    has_byte <= has;
    last_byte <= ends;
    do @(posedge clk); while (!in_ready);
    if (has || ends) items_sent++;
  endtask

  task automatic send_key(input int len, input bit closing_item);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !closing_item);
    end
    if (len == 0 || closing_item) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (hashes_due == 0);
  endtask

  task automatic load_seed(input logic [31:0] value);
    drain();
    repeat (20) @(posedge clk);
    seed_we <= 1'b1;
    seed_data <= value;
    @(posedge clk);
    seed_we <= 1'b0;
  endtask

  initial begin
    int pick;
    int len;
    int target;
    clk = 1'b0;
    rst = 1'b1;
    seed_we = 1'b0;
    seed_data = '0;
    data_byte = '0;
    has_byte = 1'b0;
    last_byte = 1'b0;
    in_valid = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    send_steady = 1'b0;
    seed_plan[0] = 32'hffffffff;
    seed_plan[1] = 32'h00000000;
    seed_plan[2] = $urandom;
    seed_plan[3] = 32'h00000001;
    seed_plan[4] = $urandom;
    seed_plan[5] = 32'h80000000;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Idle transaction, empty key, single-byte extremes, a key of exactly one
    // block, and a key closed by a transaction that carries no byte.
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    for (int i = 0; i < 12; i++) send_item(i[0] ? 8'hff : 8'h00, 1'b1, i == 11);
    for (int i = 0; i < 10; i++) send_item(8'h80 >> (i % 8), 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    for (int p = 0; p < 6; p++) begin
      load_seed(seed_plan[p]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) len = 0;
        else if (pick < 75) len = $urandom_range(1, 24);
        else if (pick < 95) len = $urandom_range(25, 48);
        else len = $urandom_range(49, 100);
        send_key(len, $urandom_range(0, 4) == 0);
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("byte_hash_32bit_lookup2 regression: pass");
    end else begin
      $display("byte_hash_32bit_lookup2 regression: fail");
    end
    $finish;
  end

  // The receiver stalls at random and, once, for long enough that the block
  // fills up and holds off the sender.
  initial begin
    int stall;
    out_ready = 1'b0;
    hashes_taken = 0;
    take_steady = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 9) == 0) take_steady = !take_steady;
      stall = take_steady ? 0 : $urandom_range(0, 15);
      if (hashes_taken == 30) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      hashes_taken++;
    end
  end

endmodule

// ===== filelist.f =====
src/bhl_pkg.sv
src/bhl_front.sv
src/bhl_queue.sv
src/bhl_back.sv
src/byte_hash_32bit_lookup2.sv
dv/byte_hash_32bit_lookup2_check.sv
dv/byte_hash_32bit_lookup2_test.sv
